// ----- sv/dcb_pkg.sv -----
// Shared constants and types for the DMA descriptor chain builder.
// No dependencies.
package dcb_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CHUNK_W     = 13;
  localparam int unsigned TOTAL_W     = 20;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned MAX_DESC_LG = 6;   // 64 descriptors per chain

  localparam logic [CFG_IDX_W-1:0] REG_CHAIN_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INC_SRC    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INC_TRG    = 2'd3;

  localparam logic [ADDR_W-1:0]  STOP_LINK      = 32'h0000_0001;
  localparam logic [ADDR_W-1:0]  DESC_BYTES     = 32'h0000_0010;
  localparam logic [ADDR_W-1:0]  LINK_MASK      = 32'hFFFF_FFF0;
  localparam logic [ADDR_W-1:0]  RST_CHAIN_BASE = 32'h0000_0000;
  localparam logic [CHUNK_W-1:0] RST_CHUNK_LEN  = 13'd4096;

  typedef struct packed {
    logic               last;
    logic [CHUNK_W-1:0] bytes;
    logic [TOTAL_W-1:0] rem_nxt;
    logic [ADDR_W-1:0]  src_nxt;
    logic [ADDR_W-1:0]  trg_nxt;
    logic [ADDR_W-1:0]  link_nxt;
  } dcb_step_t;

endpackage

// ----- sv/dcb_chunk_unit.sv -----
// Shared chunk step: compare/subtract of remaining bytes and address advance.
// Depends on dcb_pkg.
module dcb_chunk_unit (
  input  logic [dcb_pkg::TOTAL_W-1:0] rem,
  input  logic [dcb_pkg::CHUNK_W-1:0] step,
  input  logic [dcb_pkg::ADDR_W-1:0]  src,
  input  logic [dcb_pkg::ADDR_W-1:0]  trg,
  input  logic [dcb_pkg::ADDR_W-1:0]  link,
  input  logic                        inc_src,
  input  logic                        inc_trg,
  output dcb_pkg::dcb_step_t          res
);
  import dcb_pkg::*;

  logic [TOTAL_W-1:0] step_ext;
  logic [ADDR_W-1:0]  step_addr;
  logic               full;

  assign step_ext  = {{(TOTAL_W-CHUNK_W){1'b0}}, step};
  assign step_addr = {{(ADDR_W-CHUNK_W){1'b0}}, step};
  assign full      = rem > step_ext;

  always_comb begin
    res.last     = !full;
    res.bytes    = full ? step : rem[CHUNK_W-1:0];
    res.rem_nxt  = rem - step_ext;
    res.src_nxt  = inc_src ? src + step_addr : src;
    res.trg_nxt  = inc_trg ? trg + step_addr : trg;
    res.link_nxt = link + DESC_BYTES;
  end

endmodule

// ----- sv/dma_descriptor_chain_builder.sv -----
// Top level: request intake, descriptor sequencer and output register.
// Depends on dcb_pkg and dcb_chunk_unit.
//
//   port group  | dir | handshake        | carries
//   cfg_*       | in  | cfg_we           | register index and write data
//   in_*        | in  | in_valid/stall   | source, target, total bytes
//   out_*       | out | out_valid/stall  | one descriptor per transfer
//
// A request is taken by intake, then the sequencer produces one descriptor a
// cycle while out_stall does not hold the output register, using the single
// remaining-bytes subtractor; an error request yields one error descriptor.
// in_stall is high while a chain is being produced.
// Reset is synchronous, active low; only config, state and out_valid are reset.
// out_stall holds the output register; the sequencer waits on it.
module dma_descriptor_chain_builder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcb_pkg::ADDR_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dcb_pkg::ADDR_W-1:0]    in_source_address,
  input  logic [dcb_pkg::ADDR_W-1:0]    in_target_address,
  input  logic [dcb_pkg::TOTAL_W-1:0]   in_total_bytes,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dcb_pkg::ADDR_W-1:0]    out_next_link,
  output logic [dcb_pkg::ADDR_W-1:0]    out_chunk_source,
  output logic [dcb_pkg::ADDR_W-1:0]    out_chunk_target,
  output logic [dcb_pkg::CHUNK_W-1:0]   out_chunk_bytes,
  output logic                          out_is_last,
  output logic                          out_error_flag
);
  import dcb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   base_r;
  logic [CHUNK_W-1:0]  step_r;
  logic                inc_src_r, inc_trg_r;

  logic [TOTAL_W-1:0]  rem_r, rem_nxt;
  logic [ADDR_W-1:0]   src_r, src_nxt;
  logic [ADDR_W-1:0]   trg_r, trg_nxt;
  logic [ADDR_W-1:0]   link_r, link_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_link_r, out_link_nxt;
  logic [ADDR_W-1:0]   out_src_r, out_src_nxt;
  logic [ADDR_W-1:0]   out_trg_r, out_trg_nxt;
  logic [CHUNK_W-1:0]  out_bytes_r, out_bytes_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_err_r, out_err_nxt;

  dcb_step_t           step_res;
  logic                in_xfer;
  logic                out_free;
  logic                req_err;
  logic [TOTAL_W-1:0]  max_bytes;

  dcb_chunk_unit u_chunk (
    .rem     (rem_r),
    .step    (step_r),
    .src     (src_r),
    .trg     (trg_r),
    .link    (link_r),
    .inc_src (inc_src_r),
    .inc_trg (inc_trg_r),
    .res     (step_res)
  );

  assign in_stall  = state_r != ST_IDLE;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign max_bytes = {{(TOTAL_W-CHUNK_W-MAX_DESC_LG){1'b0}}, step_r, {MAX_DESC_LG{1'b0}}};
  assign req_err   = (in_total_bytes == '0) || (step_r == '0) || (in_total_bytes > max_bytes);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= RST_CHAIN_BASE;
      step_r    <= RST_CHUNK_LEN;
      inc_src_r <= 1'b1;
      inc_trg_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHAIN_BASE: base_r    <= cfg_wdata;
        REG_CHUNK_LEN:  step_r    <= cfg_wdata[CHUNK_W-1:0];
        REG_INC_SRC:    inc_src_r <= cfg_wdata[0];
        REG_INC_TRG:    inc_trg_r <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    src_nxt       = src_r;
    trg_nxt       = trg_r;
    link_nxt      = link_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_link_nxt  = out_link_r;
    out_src_nxt   = out_src_r;
    out_trg_nxt   = out_trg_r;
    out_bytes_nxt = out_bytes_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          rem_nxt   = in_total_bytes;
          src_nxt   = in_source_address;
          trg_nxt   = in_target_address;
          link_nxt  = base_r + DESC_BYTES;
          state_nxt = req_err ? ST_ERR : ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_link_nxt  = step_res.last ? STOP_LINK : (link_r & LINK_MASK);
          out_src_nxt   = src_r;
          out_trg_nxt   = trg_r;
          out_bytes_nxt = step_res.bytes;
          out_last_nxt  = step_res.last;
          out_err_nxt   = 1'b0;
          rem_nxt       = step_res.rem_nxt;
          src_nxt       = step_res.src_nxt;
          trg_nxt       = step_res.trg_nxt;
          link_nxt      = step_res.link_nxt;
          if (step_res.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_link_nxt  = '0;
          out_src_nxt   = '0;
          out_trg_nxt   = '0;
          out_bytes_nxt = '0;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    src_r       <= src_nxt;
    trg_r       <= trg_nxt;
    link_r      <= link_nxt;
    out_link_r  <= out_link_nxt;
    out_src_r   <= out_src_nxt;
    out_trg_r   <= out_trg_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_next_link    = out_link_r;
  assign out_chunk_source = out_src_r;
  assign out_chunk_target = out_trg_r;
  assign out_chunk_bytes  = out_bytes_r;
  assign out_is_last      = out_last_r;
  assign out_error_flag   = out_err_r;

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r && out_link_r == '0 && out_bytes_r == '0)
    else $error("error result malformed");

  a_last_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r && !out_err_r |-> out_link_r == STOP_LINK)
    else $error("last descriptor without stop link");

  a_mid_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_bytes_r == step_r && out_link_r[3:0] == 4'h0)
    else $error("inner descriptor not a full aligned chunk");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("request taken while chain pending");

endmodule
